>>> hdl/sht_pkg.sv
`timescale 1ns / 1ps

package sht_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    localparam int PID_W   = 16;
    localparam int SIG_W   = 4;
    localparam int HID_W   = 8;
    localparam int KEY_W   = PID_W + SIG_W;
    localparam int ENTRY_W = KEY_W + HID_W;
    localparam int OUTC_W  = 3;
    localparam int CNTO_W  = 5;

    // action codes
    localparam logic [1:0] ACTION_REG   = 2'd0;
    localparam logic [1:0] ACTION_UNREG = 2'd1;
    localparam logic [1:0] ACTION_DISP  = 2'd2;

    // outcome codes
    localparam logic [OUTC_W-1:0] OUTC_TERM   = 3'd0;
    localparam logic [OUTC_W-1:0] OUTC_IGNORE = 3'd1;
    localparam logic [OUTC_W-1:0] OUTC_STOP   = 3'd2;
    localparam logic [OUTC_W-1:0] OUTC_CONT   = 3'd3;
    localparam logic [OUTC_W-1:0] OUTC_CUSTOM = 3'd4;

    // signal codes
    localparam logic [SIG_W-1:0] SIGNO_TERM = 4'd0;
    localparam logic [SIG_W-1:0] SIGNO_KILL = 4'd1;
    localparam logic [SIG_W-1:0] SIGNO_INT  = 4'd2;
    localparam logic [SIG_W-1:0] SIGNO_HUP  = 4'd3;
    localparam logic [SIG_W-1:0] SIGNO_USR1 = 4'd4;
    localparam logic [SIG_W-1:0] SIGNO_USR2 = 4'd5;
    localparam logic [SIG_W-1:0] SIGNO_CHLD = 4'd6;
    localparam logic [SIG_W-1:0] SIGNO_STOP = 4'd7;
    localparam logic [SIG_W-1:0] SIGNO_CONT = 4'd8;
    localparam logic [SIG_W-1:0] NUM_SIGS   = 4'd9;

    typedef struct packed {
        logic load;         // capture the input item
        logic search_step;  // issue next lookup read
        logic write_entry;  // store register entry (hit slot or append)
        logic count_inc;
        logic count_dec;
        logic set_ok;
        logic set_custom;   // capture handler of the hit entry
        logic start_shift;  // begin closing the gap after the hit slot
        logic shift_step;
        logic out_load;
    } sht_cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       need_search;
        logic       hit;
        logic       hit_nonzero;
        logic       exhausted;
        logic       room;
        logic       out_free;
    } sht_status_t;

    function automatic logic [OUTC_W-1:0] default_act(input logic [SIG_W-1:0] sig);
        logic [OUTC_W-1:0] res;
        case (sig)
            SIGNO_TERM, SIGNO_KILL, SIGNO_INT, SIGNO_HUP: res = OUTC_TERM;
            SIGNO_USR1, SIGNO_USR2, SIGNO_CHLD:           res = OUTC_IGNORE;
            SIGNO_STOP:                                   res = OUTC_STOP;
            SIGNO_CONT:                                   res = OUTC_CONT;
            default:                                      res = OUTC_IGNORE;
        endcase
        return res;
    endfunction

endpackage

>>> hdl/sht_ram.sv
`timescale 1ns / 1ps

module sht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/sht_ctrl.sv
`timescale 1ns / 1ps

module sht_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sht_pkg::sht_status_t status,
    output sht_pkg::sht_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_SHIFT  = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (!status.need_search) begin
                    state_next = ST_RESULT;
                end else if (status.hit || status.exhausted) begin
                    state_next = ST_RESULT;
                    case (status.action)
                        sht_pkg::ACTION_REG: begin
                            if (status.hit) begin
                                cmd.write_entry = 1'b1;
                                cmd.set_ok      = 1'b1;
                            end else if (status.room) begin
                                cmd.write_entry = 1'b1;
                                cmd.count_inc   = 1'b1;
                                cmd.set_ok      = 1'b1;
                            end
                        end
                        sht_pkg::ACTION_UNREG: begin
                            if (status.hit) begin
                                cmd.start_shift = 1'b1;
                                state_next      = ST_SHIFT;
                            end
                        end
                        sht_pkg::ACTION_DISP: begin
                            cmd.set_custom = status.hit && status.hit_nonzero;
                        end
                        default: ;
                    endcase
                end else begin
                    cmd.search_step = 1'b1;
                end
            end
            ST_SHIFT: begin
                if (status.exhausted) begin
                    cmd.count_dec = 1'b1;
                    cmd.set_ok    = 1'b1;
                    state_next    = ST_RESULT;
                end else begin
                    cmd.shift_step = 1'b1;
                end
            end
            ST_RESULT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

>>> hdl/sht_datapath.sv
`timescale 1ns / 1ps

module sht_datapath #(
    parameter int TABLE_DEPTH = sht_pkg::TABLE_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  sht_pkg::sht_cmd_t            cmd,
    output sht_pkg::sht_status_t         status,
    input  logic [1:0]                   s_action,
    input  logic [sht_pkg::PID_W-1:0]    s_pid,
    input  logic [sht_pkg::SIG_W-1:0]    s_sig,
    input  logic [sht_pkg::HID_W-1:0]    s_handler_id,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_ok,
    output logic [sht_pkg::OUTC_W-1:0]   m_outcome,
    output logic                         m_uncatchable,
    output logic [sht_pkg::HID_W-1:0]    m_found_handler,
    output logic [sht_pkg::CNTO_W-1:0]   m_entry_count
);

    localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W = sht_pkg::ENTRY_W;
    localparam int HID_W   = sht_pkg::HID_W;

    // captured item
    logic [1:0]                action_reg;
    logic [sht_pkg::PID_W-1:0] pid_reg;
    logic [sht_pkg::SIG_W-1:0] sig_reg;
    logic [HID_W-1:0]          hid_reg;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] pend_idx_reg, pend_idx_next;
    logic              ok_reg, custom_reg;
    logic [HID_W-1:0]  hd_reg;

    logic              m_valid_reg;
    logic              m_ok_reg;
    logic [sht_pkg::OUTC_W-1:0] m_outcome_reg;
    logic              m_uncatchable_reg;
    logic [HID_W-1:0]  m_found_reg;
    logic [sht_pkg::CNTO_W-1:0] m_count_reg;

    logic              known, fixed, is_disp;
    logic              rd_more, step;
    logic [ENTRY_W-1:0] rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [31:0]       count_ext;
    logic [sht_pkg::OUTC_W-1:0] outcome_val;

    assign known   = (sig_reg < sht_pkg::NUM_SIGS);
    assign fixed   = (sig_reg == sht_pkg::SIGNO_KILL) || (sig_reg == sht_pkg::SIGNO_STOP);
    assign is_disp = (action_reg == sht_pkg::ACTION_DISP);

    assign rd_more = (rd_idx_reg < count_reg);
    assign step    = cmd.search_step || cmd.shift_step;

    always_comb begin
        status.action      = action_reg;
        status.need_search = known && ((action_reg == sht_pkg::ACTION_UNREG) ||
                             (((action_reg == sht_pkg::ACTION_REG) || is_disp) && !fixed));
        status.hit         = pend_reg && (rd_data[ENTRY_W-1:HID_W] == {pid_reg, sig_reg});
        status.hit_nonzero = (rd_data[HID_W-1:0] != '0);
        status.exhausted   = !pend_reg && !rd_more;
        status.room        = (count_reg < CNT_W'(TABLE_DEPTH));
        status.out_free    = !m_valid_reg || m_ready;
    end

    // read pipeline shared by lookup and gap closing
    always_comb begin
        rd_idx_next   = rd_idx_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        if (cmd.load) begin
            rd_idx_next = '0;
        end else if (cmd.start_shift) begin
            rd_idx_next = CNT_W'(pend_idx_reg) + CNT_W'(1);
        end else if (step && rd_more) begin
            rd_idx_next   = rd_idx_reg + CNT_W'(1);
            pend_next     = 1'b1;
            pend_idx_next = rd_idx_reg[ADDR_W-1:0];
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = pend_idx_reg;
        wr_data = {pid_reg, sig_reg, hid_reg};
        if (cmd.write_entry) begin
            wr_en   = 1'b1;
            // overwrite the hit slot, else append at the end
            wr_addr = status.hit ? pend_idx_reg : count_reg[ADDR_W-1:0];
        end else if (cmd.shift_step && pend_reg) begin
            wr_en   = 1'b1;
            wr_addr = pend_idx_reg - ADDR_W'(1);
            wr_data = rd_data;
        end
    end

    sht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH),
        .ADDR_W(ADDR_W)
    ) u_table (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_idx_reg[ADDR_W-1:0]),
        .rd_data(rd_data)
    );

    always_comb begin
        count_next = count_reg;
        if (cmd.count_inc) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.count_dec) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg   <= rd_idx_next;
        pend_idx_reg <= pend_idx_next;
        if (cmd.load) begin
            action_reg <= s_action;
            pid_reg    <= s_pid;
            sig_reg    <= s_sig;
            hid_reg    <= s_handler_id;
            ok_reg     <= 1'b0;
            custom_reg <= 1'b0;
        end else begin
            if (cmd.set_ok) begin
                ok_reg <= 1'b1;
            end
            if (cmd.set_custom) begin
                custom_reg <= 1'b1;
                hd_reg     <= rd_data[HID_W-1:0];
            end
        end
    end

    // result register
    assign count_ext = 32'(count_reg);

    always_comb begin
        if (!is_disp) begin
            outcome_val = sht_pkg::OUTC_TERM;
        end else if (!known) begin
            outcome_val = sht_pkg::OUTC_IGNORE;
        end else if (custom_reg) begin
            outcome_val = sht_pkg::OUTC_CUSTOM;
        end else begin
            outcome_val = sht_pkg::default_act(sig_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_ok_reg          <= is_disp || ok_reg;
            m_outcome_reg     <= outcome_val;
            m_uncatchable_reg <= fixed;
            m_found_reg       <= custom_reg ? hd_reg : '0;
            m_count_reg       <= count_ext[sht_pkg::CNTO_W-1:0];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_ok            = m_ok_reg;
    assign m_outcome       = m_outcome_reg;
    assign m_uncatchable   = m_uncatchable_reg;
    assign m_found_handler = m_found_reg;
    assign m_entry_count   = m_count_reg;

endmodule

>>> hdl/signal_handler_table_top.sv
`timescale 1ns / 1ps

// signal handler table: maps (pid, sig) keys to handler ids in a packed table
// input channel s_*: one item is an action (register, unregister, dispatch),
// a pid, a signal code and a handler id; accepted when s_valid and s_ready
// output channel m_*: one result item per input item, held in an output
// register until m_valid and m_ready are both high
// items are processed one at a time; s_ready is high only while idle
// steps: the item is captured, then a lookup reads one table slot per
// cycle from the single-port-read table ram, an unregister then shifts
// later entries down to close the gap, and the result is loaded into the
// output register
// unknown signals, unused actions and kill/stop reg/dispatch skip the lookup
// the next item is taken the cycle after the result is registered
// a stalled receiver holds the result; a second finished item waits in the
// block until the output register frees, with s_ready low meanwhile
// reset empties the table (entry count 0) and clears both channels;
// table contents need no clearing pass
module signal_handler_table_top #(
    parameter int TABLE_DEPTH = sht_pkg::TABLE_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_action,
    input  logic [sht_pkg::PID_W-1:0]    s_pid,
    input  logic [sht_pkg::SIG_W-1:0]    s_sig,
    input  logic [sht_pkg::HID_W-1:0]    s_handler_id,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_ok,
    output logic [sht_pkg::OUTC_W-1:0]   m_outcome,
    output logic                         m_uncatchable,
    output logic [sht_pkg::HID_W-1:0]    m_found_handler,
    output logic [sht_pkg::CNTO_W-1:0]   m_entry_count
);

    sht_pkg::sht_cmd_t    cmd;
    sht_pkg::sht_status_t status;

    sht_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .status (status),
        .cmd    (cmd)
    );

    sht_datapath #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_action       (s_action),
        .s_pid          (s_pid),
        .s_sig          (s_sig),
        .s_handler_id   (s_handler_id),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_ok           (m_ok),
        .m_outcome      (m_outcome),
        .m_uncatchable  (m_uncatchable),
        .m_found_handler(m_found_handler),
        .m_entry_count  (m_entry_count)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("block took a second item while busy");

    a_custom_has_handler: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_outcome == sht_pkg::OUTC_CUSTOM) |-> m_found_handler != '0)
        else $error("custom outcome with zero handler");

    a_handler_only_custom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_found_handler != '0) |-> m_outcome == sht_pkg::OUTC_CUSTOM)
        else $error("handler reported without custom outcome");

    a_fixed_not_custom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_uncatchable |-> m_outcome != sht_pkg::OUTC_CUSTOM)
        else $error("uncatchable signal dispatched to a handler");
`endif

endmodule
